// ----- src/decimating_fir_complex_defines.svh -----
// assertion macros shared by the checker
`ifndef DECIMATING_FIR_COMPLEX_DEFINES_SVH
`define DECIMATING_FIR_COMPLEX_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define DFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while in reset
`define DFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dfc_pkg.sv -----
// shared types and constants of the decimating complex fir
package dfc_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int MAX_TAPS_DEF   = 64;
  localparam int MAX_DECIM_DEF  = 256;
  localparam int TAPCNT_W       = 7;
  localparam int DECIM_W        = 9;
  localparam int CIDX_W         = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM     = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [DATA_WIDTH-1:0]  sample_i;
    logic signed [DATA_WIDTH-1:0]  sample_q;
    logic        [CIDX_W-1:0]      coef_index;
    logic signed [DATA_WIDTH-1:0]  coef_i;
    logic signed [DATA_WIDTH-1:0]  coef_q;
  } dfc_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  out_i;
    logic signed [DATA_WIDTH-1:0]  out_q;
    logic                          saturated;
  } dfc_out_t;

endpackage

// ----- src/dfc_front.sv -----
// input side: accepts words and queues them for the engine
module dfc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dfc_pkg::dfc_in_t in_data,
  output logic             q_valid,
  output dfc_pkg::dfc_in_t q_item,
  input  logic             q_pop
);
  import dfc_pkg::*;

  dfc_in_t     buf_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_data;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- src/dfc_engine.sv -----
// back end: delay line, coefficient store, mac sequencer and output register
module dfc_engine #(
  parameter int MAX_TAPS  = dfc_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIM = dfc_pkg::MAX_DECIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          q_valid,
  input  dfc_pkg::dfc_in_t              q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dfc_pkg::dfc_out_t             out_data
);
  import dfc_pkg::*;

  localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int PH_W  = (MAX_DECIM > 1) ? $clog2(MAX_DECIM + 1) : 1;
  localparam int ACC_W = 2 * DATA_WIDTH + CNT_W + 1;
  localparam int SH    = DATA_WIDTH - 1;
  localparam int Q_W   = ACC_W + 1 - SH;
  localparam int EW    = 2 * DATA_WIDTH;

  typedef enum logic [2:0] {S_IDLE, S_FOLD, S_RUN, S_DRAIN, S_FINISH} state_t;

  // configuration
  logic [TAPCNT_W-1:0] tap_count_r;
  logic [DECIM_W-1:0]  decim_r;
  logic [CNT_W-1:0]    taps_use;
  logic [PH_W-1:0]     decim_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCNT_W'(64);
      decim_r     <= DECIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count_r <= cfg_wdata[TAPCNT_W-1:0];
        REG_DECIM:     decim_r     <= cfg_wdata[DECIM_W-1:0];
        default:       ;
      endcase
    end
  end

  // clamp registers into usable range
  always_comb begin
    int t, d;
    t = int'(tap_count_r);
    d = int'(decim_r);
    if (t == 0) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    if (d == 0) d = 1;
    if (d > MAX_DECIM) d = MAX_DECIM;
    taps_use  = CNT_W'(t);
    decim_use = PH_W'(d);
  end

  // memories with per-entry valid bits (invalid reads as zero)
  logic [EW-1:0]    dl_mem [MAX_TAPS];
  logic [EW-1:0]    cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] dl_vld_r, cf_vld_r;
  logic             dl_we, cf_we, rd_en;
  logic [TAP_W-1:0] dl_waddr, cf_waddr, slot_r, slot_nxt;
  logic [EW-1:0]    dl_wdata, cf_wdata, dl_rd_r, cf_rd_r;
  logic             dl_rv_r, cf_rv_r;
  logic [CNT_W-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
    if (cf_we) cf_mem[cf_waddr] <= cf_wdata;
    if (rd_en) begin
      dl_rd_r <= dl_mem[slot_r];
      cf_rd_r <= cf_mem[k_r[TAP_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_vld_r <= '0;
      cf_vld_r <= '0;
      dl_rv_r  <= 1'b0;
      cf_rv_r  <= 1'b0;
    end else begin
      if (dl_we) dl_vld_r[dl_waddr] <= 1'b1;
      if (cf_we) cf_vld_r[cf_waddr] <= 1'b1;
      if (rd_en) begin
        dl_rv_r <= dl_vld_r[slot_r];
        cf_rv_r <= cf_vld_r[k_r[TAP_W-1:0]];
      end
    end
  end

  // item decode
  logic [CIDX_W+TAP_W-1:0] cidx_ext;
  logic [TAP_W-1:0]        wpos_r, wpos_use, wpos_inc;

  assign cidx_ext = (CIDX_W + TAP_W)'(q_item.coef_index);
  assign cf_waddr = cidx_ext[TAP_W-1:0];
  assign cf_wdata = {q_item.coef_i, q_item.coef_q};
  assign dl_wdata = {q_item.sample_i, q_item.sample_q};
  assign wpos_use = (CNT_W'(wpos_r) >= taps_use) ? '0 : wpos_r;
  assign wpos_inc = (CNT_W'(wpos_use) + CNT_W'(1) >= taps_use) ? '0 : wpos_use + TAP_W'(1);
  assign dl_waddr = wpos_use;

  state_t state_r;
  logic   emit_r;
  logic [PH_W-1:0] phase_r;
  logic [PH_W:0]   phase_inc;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign dl_we     = q_pop && (q_item.op == OP_SAMPLE);
  assign cf_we     = q_pop && (q_item.op == OP_COEF) && (int'(cidx_ext) < MAX_TAPS);
  assign phase_inc = {1'b0, phase_r} + (PH_W+1)'(1);
  assign rd_en     = (state_r == S_RUN);
  assign k_nxt     = k_r + CNT_W'(1);
  assign slot_nxt  = (CNT_W'(slot_r) + CNT_W'(1) >= taps_use) ? '0 : slot_r + TAP_W'(1);

  // multiply and accumulate pipeline
  logic signed [DATA_WIDTH-1:0] si, sq, ci, cq;
  logic signed [EW-1:0] p_ii_r, p_qq_r, p_iq_r, p_qi_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic rd_v_r, mul_v_r;

  assign si = dl_rv_r ? dl_rd_r[EW-1:DATA_WIDTH] : '0;
  assign sq = dl_rv_r ? dl_rd_r[DATA_WIDTH-1:0]  : '0;
  assign ci = cf_rv_r ? cf_rd_r[EW-1:DATA_WIDTH] : '0;
  assign cq = cf_rv_r ? cf_rd_r[DATA_WIDTH-1:0]  : '0;

  always_ff @(posedge clk) begin
    p_ii_r <= si * ci;
    p_qq_r <= sq * cq;
    p_iq_r <= si * cq;
    p_qi_r <= sq * ci;
  end

  // round half up and saturate
  logic signed [ACC_W:0]   v_re, v_im;
  logic signed [Q_W-1:0]   q_re, q_im;
  logic                    hi_re, lo_re, hi_im, lo_im;
  localparam logic signed [Q_W-1:0] Q_HI = Q_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - Q_W'(1);
  dfc_out_t res;

  always_comb begin
    v_re  = (ACC_W+1)'(acc_re_r) + ((ACC_W+1)'(1) <<< (SH - 1));
    v_im  = (ACC_W+1)'(acc_im_r) + ((ACC_W+1)'(1) <<< (SH - 1));
    q_re  = Q_W'(v_re >>> SH);
    q_im  = Q_W'(v_im >>> SH);
    hi_re = q_re > Q_HI;
    lo_re = q_re < Q_LO;
    hi_im = q_im > Q_HI;
    lo_im = q_im < Q_LO;
    res.out_i = hi_re ? DATA_WIDTH'(Q_HI) : lo_re ? DATA_WIDTH'(Q_LO) : q_re[DATA_WIDTH-1:0];
    res.out_q = hi_im ? DATA_WIDTH'(Q_HI) : lo_im ? DATA_WIDTH'(Q_LO) : q_im[DATA_WIDTH-1:0];
    res.saturated = hi_re || lo_re || hi_im || lo_im;
  end

  // sequencer, position and phase, output register
  logic     out_valid_r;
  dfc_out_t out_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_r      <= 1'b0;
      phase_r     <= '0;
      wpos_r      <= '0;
      k_r         <= '0;
      slot_r      <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r  <= rd_en;
      mul_v_r <= rd_v_r;
      if (mul_v_r) begin
        acc_re_r <= acc_re_r + ACC_W'(p_ii_r) - ACC_W'(p_qq_r);
        acc_im_r <= acc_im_r + ACC_W'(p_iq_r) + ACC_W'(p_qi_r);
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (dl_we) begin
            wpos_r   <= wpos_inc;
            slot_r   <= wpos_inc;
            k_r      <= '0;
            acc_re_r <= '0;
            acc_im_r <= '0;
            emit_r   <= (phase_r == '0);
            phase_r  <= phase_inc[PH_W-1:0];
            if (phase_inc >= {1'b0, decim_use}) state_r <= S_FOLD;
            else if (phase_r == '0)             state_r <= S_RUN;
          end
        end
        S_FOLD: begin
          // fold a stale phase back under the factor
          phase_r <= phase_r - decim_use;
          if (phase_r - decim_use < decim_use) state_r <= emit_r ? S_RUN : S_IDLE;
        end
        S_RUN: begin
          k_r    <= k_nxt;
          slot_r <= slot_nxt;
          if (k_nxt >= taps_use) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!rd_v_r && !mul_v_r) state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/decimating_fir_complex.sv -----
// Decimating complex FIR, Q1.15 in and out. Words are queued two deep, then run one at a
// time. A sample that emits nothing returns to idle, first passing through the fold state
// when it ends a decimation period, where the phase wraps. When a sample emits, the single
// complex multiply-accumulate unit walks the taps in use one per cycle, then drains the
// read and product registers and loads the output register, waiting there while a held
// result is not taken. The phase wraps on every sample at decimation 1, and a wrapping
// sample passes through the fold state before its taps run. After the decimation factor
// is lowered, the first wrap may repeat the fold step until a stale phase is back in
// range. Coefficient 0 pairs with the oldest sample in the delay line.
module decimating_fir_complex #(
  parameter int MAX_TAPS  = dfc_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIM = dfc_pkg::MAX_DECIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dfc_pkg::dfc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dfc_pkg::dfc_out_t              out_data
);
  import dfc_pkg::*;

  logic    q_valid, q_pop;
  dfc_in_t q_item;

  // front queue
  dfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // filter engine
  dfc_engine #(
    .MAX_TAPS  (MAX_TAPS),
    .MAX_DECIM (MAX_DECIM)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/dfc_checker.sv -----
// port-level checks for the decimating complex fir, bound to the top level
`include "decimating_fir_complex_defines.svh"

module dfc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dfc_pkg::dfc_out_t out_data
);
  import dfc_pkg::*;

  // a stalled result word holds
  `DFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // an offered input word always sees a defined ready
  `DFC_ASSERT_NOW(a_in_ready_known, in_valid, !$isunknown(in_ready), "input ready unknown")

  // a result word carries no unknown bits
  `DFC_ASSERT_NOW(a_out_known, out_valid, !$isunknown(out_data), "result word has unknown bits")

  // a clip flag means a part sits at a rail
  `DFC_ASSERT_NOW(a_sat_rail, out_valid && out_data.saturated, (out_data.out_i == 16'sh7fff) || (out_data.out_i == 16'sh8000) || (out_data.out_q == 16'sh7fff) || (out_data.out_q == 16'sh8000), "clip flag without rail value")

endmodule

bind decimating_fir_complex dfc_checker u_dfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
